// ----- src/ursc_pkg.sv -----
// Shared types and constants for the ultrasonic range stop controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ursc_pkg;

    // Field and register widths.
    localparam int PERIOD_W   = 16;
    localparam int TRIG_W     = 8;
    localparam int COUNT_W    = 17;
    localparam int DIST_W     = 12;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_ADDR_W = 2;

    // Stream payload widths; the data fields are whole bytes.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP    = 2'd3;

    // Register values after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd60000;
    localparam logic [TRIG_W-1:0]   TRIGGER_RESET = 8'd10;
    localparam logic [COUNT_W-1:0]  TIMEOUT_RESET = 17'd100000;
    localparam logic [DIST_W-1:0]   STOP_RESET    = 12'd15;

    // Width to centimeters is width*34/2000 = width*17/1000. The reciprocal
    // ceil(2^31/1000) = 2147484, folded with the factor 17, is exact for every
    // 17-bit width.
    localparam int              DIST_MUL_W = 26;
    localparam int              DIST_SHIFT = 31;
    localparam int              DIST_PROD_W = COUNT_W + DIST_MUL_W;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = 26'd36507228;

    // Measurement phases.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    // Current register settings as seen by the ranging logic.
    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [TRIG_W-1:0]   trigger_ticks;
        logic [COUNT_W-1:0]  timeout_ticks;
        logic [DIST_W-1:0]   stop_distance_cm;
    } cfg_t;

endpackage

// ----- src/ultrasonic_range_stop_controller.sv -----
// Top level of the ultrasonic range stop controller: tick handshake, ranging
// state, result register. Depends on ursc_pkg, ursc_cfg_regs and ursc_dist.
//
//   Channel  Dir  Handshake            Payload
//   s_       in   s_tvalid / s_tready  s_tdata: echo_level
//   m_       out  m_tvalid / m_tready  m_tdata: trigger, motor, distance
//                                      m_tuser: distance_valid, timed_out
//   cfg_     in   cfg_we (no wait)     cfg_addr, cfg_wdata
//
// Every accepted item yields one result item, and a new item is taken in
// every cycle while no result is stalled. The single result register
// holds the whole state update and the width-to-distance multiply before it.
// Reset (synchronous, active low) idles the ranger and loads register
// defaults. A stalled result holds s_tready low until it is taken.
`timescale 1ns / 1ps

module ultrasonic_range_stop_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Tick items. s_tdata: [0] echo_level, [7:1] zero.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ursc_pkg::S_DATA_W-1:0]   s_tdata,
    // Result items. m_tdata: [0] trigger_level, [1] motor_enable,
    // [13:2] distance_cm, [15:14] zero.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ursc_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: [0] distance_valid, [1] timed_out.
    output logic [ursc_pkg::M_USER_W-1:0]   m_tuser,
    // Configuration writes.
    input  logic                            cfg_we,
    input  logic [ursc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ursc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ursc_pkg::*;

    cfg_t cfg;

    phase_t              phase_reg, phase_next;
    logic [PERIOD_W-1:0] period_count_reg, period_count_next;
    logic [COUNT_W-1:0]  phase_count_reg, phase_count_next;
    logic [COUNT_W-1:0]  echo_width_reg, echo_width_next;
    logic                motor_on_reg, motor_on_next;
    logic [DIST_W-1:0]   last_distance_reg, last_distance_next;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_USER_W-1:0] m_tuser_reg, m_tuser_next;

    logic                accept;
    logic                echo;
    logic                wrap;
    logic [PERIOD_W:0]   period_inc;
    logic [COUNT_W-1:0]  trig_count;
    logic [DIST_W-1:0]   meas_distance;
    logic [DIST_W-1:0]   fin_distance;
    logic                finish;
    logic                fin_timeout;
    logic                trig;
    phase_t              phase_eff;
    logic [COUNT_W-1:0]  count_eff;

    ursc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ursc_dist u_dist (
        .echo_width  (echo_width_reg),
        .distance_cm (meas_distance)
    );

    // The result register frees up whenever its item is taken.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign echo     = s_tdata[0];

    // Period counter: wrap when the next count reaches the period.
    assign period_inc = {1'b0, period_count_reg} + 17'd1;
    assign wrap       = period_inc >= {1'b0, cfg.period_ticks};
    assign period_count_next = wrap ? '0 : period_inc[PERIOD_W-1:0];

    // A wrap that finds the ranger idle starts the trigger pulse.
    assign phase_eff  = (phase_reg == PH_IDLE && wrap) ? PH_TRIG : phase_reg;
    assign count_eff  = (phase_reg == PH_IDLE && wrap) ? '0 : phase_count_reg;
    assign trig_count = count_eff + 17'd1;

    // Phase step for one tick.
    always_comb begin
        phase_next       = phase_eff;
        phase_count_next = count_eff;
        echo_width_next  = echo_width_reg;
        trig             = 1'b0;
        finish           = 1'b0;
        fin_timeout      = 1'b0;
        fin_distance     = '0;
        unique case (phase_eff)
            PH_TRIG: begin
                trig = 1'b1;
                if (trig_count >= {{(COUNT_W-TRIG_W){1'b0}}, cfg.trigger_ticks}) begin
                    phase_next       = PH_WAIT;
                    phase_count_next = '0;
                end else begin
                    phase_count_next = trig_count;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    phase_next       = PH_MEAS;
                    echo_width_next  = 17'd1;
                    phase_count_next = '0;
                end else if (count_eff >= cfg.timeout_ticks) begin
                    finish      = 1'b1;
                    fin_timeout = 1'b1;
                end else begin
                    phase_count_next = count_eff + 17'd1;
                end
            end
            PH_MEAS: begin
                if (echo) begin
                    if (echo_width_reg >= cfg.timeout_ticks) begin
                        finish      = 1'b1;
                        fin_timeout = 1'b1;
                    end else begin
                        echo_width_next = echo_width_reg + 17'd1;
                    end
                end else begin
                    finish       = 1'b1;
                    fin_distance = meas_distance;
                end
            end
            default: begin
                phase_next = phase_eff;
            end
        endcase
        if (finish) begin
            phase_next       = PH_IDLE;
            phase_count_next = '0;
        end
    end

    // Motor decision on completion: stop inside 1..stop_distance_cm.
    assign last_distance_next = finish ? fin_distance : last_distance_reg;
    assign motor_on_next = finish
        ? !(fin_distance != '0 && fin_distance <= cfg.stop_distance_cm)
        : motor_on_reg;

    // Pack the result item.
    assign m_tdata_next = {2'b00, last_distance_next, motor_on_next, trig};
    assign m_tuser_next = {fin_timeout, finish};

    // Ranging state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            period_count_reg  <= '0;
            phase_count_reg   <= '0;
            echo_width_reg    <= '0;
            motor_on_reg      <= 1'b0;
            last_distance_reg <= '0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            period_count_reg  <= period_count_next;
            phase_count_reg   <= phase_count_next;
            echo_width_reg    <= echo_width_next;
            motor_on_reg      <= motor_on_next;
            last_distance_reg <= last_distance_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    // Result payload loads with each accepted item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- src/ursc_cfg_regs.sv -----
// Configuration registers of the ultrasonic range stop controller.
// Depends on ursc_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module ursc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ursc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ursc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ursc_pkg::cfg_t                  cfg
);
    import ursc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index; each register keeps only its own width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PERIOD:  cfg_next.period_ticks     = cfg_wdata[PERIOD_W-1:0];
                CFG_TRIGGER: cfg_next.trigger_ticks    = cfg_wdata[TRIG_W-1:0];
                CFG_TIMEOUT: cfg_next.timeout_ticks    = cfg_wdata[COUNT_W-1:0];
                CFG_STOP:    cfg_next.stop_distance_cm = cfg_wdata[DIST_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_ticks     <= PERIOD_RESET;
            cfg_reg.trigger_ticks    <= TRIGGER_RESET;
            cfg_reg.timeout_ticks    <= TIMEOUT_RESET;
            cfg_reg.stop_distance_cm <= STOP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/ursc_dist.sv -----
// Echo pulse width to distance conversion, width*34/2000 in centimeters.
// Depends on ursc_pkg for the reciprocal constant and widths.
`timescale 1ns / 1ps

module ursc_dist (
    input  logic [ursc_pkg::COUNT_W-1:0] echo_width,
    output logic [ursc_pkg::DIST_W-1:0]  distance_cm
);
    import ursc_pkg::*;

    logic [DIST_PROD_W-1:0] product;

    // One constant multiply by the scaled reciprocal, then a shift.
    assign product = {{DIST_MUL_W{1'b0}}, echo_width}
                   * {{COUNT_W{1'b0}}, DIST_MUL};
    assign distance_cm = product[DIST_SHIFT +: DIST_W];

endmodule

// ----- sim/ultrasonic_range_stop_controller_test.sv -----
// Self-checking testbench for the ultrasonic range stop controller: drives echo
// ticks, predicts trigger, motor and distance results, and checks every result.
// Depends on ursc_pkg and ultrasonic_range_stop_controller.
`timescale 1ns / 1ps

module ultrasonic_range_stop_controller_test;

    import ursc_pkg::*;

    localparam int HOLD_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_TICKS    = 30;

    // One result item as the predictor sees it.
    typedef struct packed {
        logic              trigger_level;
        logic              motor_enable;
        logic [DIST_W-1:0] distance_cm;
        logic              distance_valid;
        logic              timed_out;
    } range_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Echo samples waiting to be sent, and results waiting to arrive.
    logic          echo_queue[$];
    range_result_t due_outputs[$];

    // Register copies used by the predictor.
    int unsigned cfg_period  = PERIOD_RESET;
    int unsigned cfg_trigger = TRIGGER_RESET;
    int unsigned cfg_timeout = TIMEOUT_RESET;
    int unsigned cfg_stop    = STOP_RESET;

    // Ranging state of the predictor.
    phase_t            ranger_phase  = PH_IDLE;
    int unsigned       period_count  = 0;
    int unsigned       phase_count   = 0;
    int unsigned       echo_width    = 0;
    logic              motor_on      = 1'b0;
    logic [DIST_W-1:0] last_distance = '0;

    // Traffic shaping knobs, set by the stimulus and read by driver and receiver.
    int tx_idle_pct       = 0;
    int rx_idle_pct       = 0;
    int long_holds_asked  = 0;
    int long_holds_served = 0;
    int tx_gap            = 0;
    int rx_stall          = 0;
    int quiet_cycles      = 0;

    // Run statistics.
    int mismatches       = 0;
    int ticks_sent       = 0;
    int measurements     = 0;
    int timeouts_seen    = 0;
    int stops_seen       = 0;
    int settings_applied = 0;

    ultrasonic_range_stop_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Close the running measurement and update the motor decision.
    function automatic void end_measurement(input int unsigned cm, input logic by_timeout,
                                            inout range_result_t r);
        last_distance    = cm[DIST_W-1:0];
        motor_on         = !(last_distance >= 1 && last_distance <= cfg_stop);
        ranger_phase     = PH_IDLE;
        phase_count      = 0;
        r.distance_valid = 1'b1;
        r.timed_out      = by_timeout;
    endfunction

    // Advance the ranger by one tick and return the result it produces.
    function automatic range_result_t range_tick(input logic echo);
        range_result_t r;
        logic          wrap;
        r            = '0;
        wrap         = (period_count + 1) >= cfg_period;
        period_count = wrap ? 0 : period_count + 1;
        // A wrap only starts a measurement when none is running.
        if (ranger_phase == PH_IDLE && wrap) begin
            ranger_phase = PH_TRIG;
            phase_count  = 0;
        end
        case (ranger_phase)
            PH_TRIG: begin
                r.trigger_level = 1'b1;
                phase_count++;
                if (phase_count >= cfg_trigger) begin
                    ranger_phase = PH_WAIT;
                    phase_count  = 0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    ranger_phase = PH_MEAS;
                    echo_width   = 1;
                    phase_count  = 0;
                end else if (phase_count >= cfg_timeout) begin
                    end_measurement(0, 1'b1, r);
                end else begin
                    phase_count++;
                end
            end
            PH_MEAS: begin
                if (!echo) begin
                    end_measurement(echo_width * 34 / 2000, 1'b0, r);
                end else if (echo_width >= cfg_timeout) begin
                    end_measurement(0, 1'b1, r);
                end else begin
                    echo_width++;
                end
            end
            default: ;
        endcase
        r.motor_enable = motor_on;
        r.distance_cm  = last_distance;
        return r;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // Sender: offers queued echo ticks, with short random gaps between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   = 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end else if (echo_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_DATA_W-1){1'b0}}, echo_queue.pop_front()};
                if ($urandom_range(99) < tx_idle_pct)
                    tx_gap = $urandom_range(3, 1);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls, plus a long hold-off when one is asked for.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else if (rx_stall != 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else if (long_holds_served != long_holds_asked) begin
            long_holds_served++;
            rx_stall = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(99) < rx_idle_pct) begin
            rx_stall = $urandom_range(2, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted tick and checks every accepted result.
    always @(posedge aclk) begin : monitor
        range_result_t want;
        range_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = range_tick(s_tdata[0]);
                due_outputs.push_back(want);
                ticks_sent++;
                if (want.distance_valid) measurements++;
                if (want.timed_out) timeouts_seen++;
                if (want.distance_valid && !want.motor_enable) stops_seen++;
            end
            if (m_tvalid && m_tready) begin
                got.trigger_level  = m_tdata[0];
                got.motor_enable   = m_tdata[1];
                got.distance_cm    = m_tdata[DIST_W+1:2];
                got.distance_valid = m_tuser[0];
                got.timed_out      = m_tuser[1];
                if (due_outputs.size() == 0) begin
                    mismatches++;
                    $error("result item arrived with no tick waiting for it");
                end else begin
                    want = due_outputs.pop_front();
                    check_field("trigger_level", want.trigger_level, got.trigger_level);
                    check_field("motor_enable", want.motor_enable, got.motor_enable);
                    check_field("distance_cm", want.distance_cm, got.distance_cm);
                    check_field("distance_valid", want.distance_valid, got.distance_valid);
                    check_field("timed_out", want.timed_out, got.timed_out);
                end
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Wait until every tick is sent and every result has come back.
    task automatic wait_drained();
        do @(negedge aclk);
        while (echo_queue.size() != 0 || s_tvalid || due_outputs.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_PERIOD:  cfg_period  = value[PERIOD_W-1:0];
            CFG_TRIGGER: cfg_trigger = value[TRIG_W-1:0];
            CFG_TIMEOUT: cfg_timeout = value[COUNT_W-1:0];
            CFG_STOP:    cfg_stop    = value[DIST_W-1:0];
            default: ;
        endcase
    endtask

    // Load all four registers while the block is idle. Bits above each
    // register's width carry random junk that the block must drop.
    task automatic program_ranger(input int unsigned period, input int unsigned trigger,
                                  input int unsigned timeout, input int unsigned stop);
        wait_drained();
        write_reg(CFG_PERIOD, CFG_DATA_W'(period | ($urandom_range(1) << PERIOD_W)));
        write_reg(CFG_TRIGGER, CFG_DATA_W'(trigger | ($urandom_range(511) << TRIG_W)));
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(timeout));
        write_reg(CFG_STOP, CFG_DATA_W'(stop | ($urandom_range(31) << DIST_W)));
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_applied++;
        @(negedge aclk);
    endtask

    task automatic queue_echo(input logic level, input int count);
        repeat (count) echo_queue.push_back(level);
    endtask

    task automatic queue_noise(input int count);
        repeat (count) echo_queue.push_back(1'($urandom));
    endtask

    task automatic queue_pattern(input string bits);
        for (int i = 0; i < bits.len(); i++)
            echo_queue.push_back(bits[i] == "1");
    endtask

    // Echo frames shaped after the current setting: junk during the trigger,
    // a low wait, a high pulse, then lows up to about the next period wrap.
    // Some frames are replaced by plain noise.
    task automatic queue_frames(input int budget);
        int added;
        int n_trig;
        int n_low;
        int n_high;
        int n_tail;
        added  = 0;
        n_trig = (cfg_trigger == 0) ? 1 : cfg_trigger;
        while (added < budget) begin
            if ($urandom_range(99) < 15) begin
                n_low = $urandom_range(8, 1);
                queue_noise(n_low);
                added += n_low;
            end else begin
                n_low  = ($urandom_range(3) == 0) ? $urandom_range(cfg_timeout + 1, 0)
                                                  : $urandom_range(2, 0);
                n_high = (cfg_timeout >= 59) ? $urandom_range(cfg_timeout + 1, 50)
                                             : $urandom_range(cfg_timeout + 1, 1);
                n_tail = $urandom_range(2, 1);
                if (cfg_period > n_trig + n_low + n_high + n_tail)
                    n_tail = cfg_period - (n_trig + n_low + n_high);
                queue_noise(n_trig);
                queue_echo(1'b0, n_low);
                queue_echo(1'b1, n_high);
                queue_echo(1'b0, n_tail);
                added += n_trig + n_low + n_high + n_tail;
            end
        end
    endtask

    // Stimulus: directed settings first, then randomized settings and frames.
    initial begin : stimulus
        int wide;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: the period is far too long to wrap, so nothing starts.
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        queue_noise(10);

        // Period lowered below the running count, zero trigger and zero timeout.
        program_ranger(5, 0, 0, 0);
        queue_pattern("0011011001110001110011010");

        // Zero period wraps every tick; exact timeout boundaries on both edges.
        program_ranger(0, 1, 3, 4095);
        queue_pattern("1000001110111110");

        // Motor stop threshold at one centimeter: a pulse just short of it,
        // then one just long enough.
        program_ranger(1, 1, 200, 1);
        queue_noise(1);
        queue_echo(1'b1, 58);
        queue_echo(1'b0, 1);
        queue_noise(1);
        queue_echo(1'b1, 59);
        queue_echo(1'b0, 1);

        // Widest timeout and the farthest measurable stop distance: a short pulse stops the motors.
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        program_ranger(1, 3, 131071, 2228);
        queue_noise(3);
        queue_echo(1'b1, 60);
        queue_echo(1'b0, 3);

        // Longest period: the count climbs without a wrap.
        program_ranger(65535, 2, 5, 5);
        queue_noise(10);

        // Randomized settings; the final phases run without any idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p >= RANDOM_PHASES - 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = $urandom_range(40, 10);
                rx_idle_pct = $urandom_range(40, 10);
            end
            wide = $urandom_range(1);
            program_ranger($urandom_range(40, 0), $urandom_range(6, 0),
                           wide ? $urandom_range(70, 60) : $urandom_range(12, 1),
                           $urandom_range(3, 0));
            queue_frames(PHASE_TICKS);
            // Hold the result side off while ticks keep coming, so the block
            // backs up and stalls its input.
            if (p == 1)
                long_holds_asked++;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("Sent %0d echo ticks under %0d register settings.",
                 ticks_sent, settings_applied);
        $display("Measurements ended: %0d, by timeout: %0d, with motors stopped: %0d.",
                 measurements, timeouts_seen, stops_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Mismatched fields: %0d", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ursc_pkg.sv
src/ursc_cfg_regs.sv
src/ursc_dist.sv
src/ultrasonic_range_stop_controller.sv
sim/ultrasonic_range_stop_controller_test.sv
